[rtl/vtdc_pkg.sv]
package vtdc_pkg;

   localparam int IMAGE_HALF_WIDTH_DEF = 320;

   localparam int CX_W     = 10;
   localparam int DIST_W   = 16;
   localparam int FWD_W    = 11;
   localparam int TURN_W   = 13;
   localparam int MAXT_W   = 12;
   localparam int CTOL_W   = 9;
   localparam int LOST_W   = 8;
   localparam int STATUS_W = 3;
   localparam int MODE_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [MODE_W-1:0] {
      MODE_SEARCH   = 2'd0,
      MODE_TRACK    = 2'd1,
      MODE_APPROACH = 2'd2,
      MODE_HALT     = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_SEARCHING  = 3'd0,
      ST_LEFT       = 3'd1,
      ST_CENTRE     = 3'd2,
      ST_RIGHT      = 3'd3,
      ST_LOST_BRIEF = 3'd4,
      ST_LOST       = 3'd5
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_TURN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TURN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FWD     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CREEP       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_TOL  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_TGT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_TOL   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_LOST_LIMIT  = 3'd7;

   localparam logic signed [TURN_W-1:0] SEARCH_TURN_RST = -13'sd1000;
   localparam logic [MAXT_W-1:0]        MAX_TURN_RST    = 12'd1250;
   localparam logic [FWD_W-1:0]         MAX_FWD_RST     = 11'd400;
   localparam logic [FWD_W-1:0]         CREEP_RST       = 11'd50;
   localparam logic [CTOL_W-1:0]        CENTRE_TOL_RST  = 9'd30;
   localparam logic [DIST_W-1:0]        DEPTH_TGT_RST   = 16'd200;
   localparam logic [DIST_W-1:0]        DEPTH_TOL_RST   = 16'd50;
   localparam logic [LOST_W-1:0]        LOST_LIMIT_RST  = 8'd5;

endpackage

[rtl/visual_tracking_drive_controller.sv]
// visual tracking drive controller
// one request transfer per control tick: detected flag, box centre x, distance,
// restart and cancel. one response transfer per request: forward speed, turn
// rate, status code, mode after the tick and the arrival flag.
// both channels use valid/stall; a transfer happens when valid is high and
// stall is low. configuration goes through csr_write_en/csr_index/csr_wdata
// and must only be written while no request is in flight.
// a request taken into the input register passes through the response register
// before it shows on the response channel. throughput is one tick per cycle
// while the response side does not stall: the steering product is formed
// as the request is registered and the mode machine, divide-by-half-width and
// command clamps run from the input register into the response register.
// when the response side stalls, the response register holds and the input
// register holds its waiting tick; req_stall rises only when both are full.
// reset (synchronous, active high) empties both stages, puts the machine in
// search with no sighting, no misses and a zero held command, and loads the
// default register values.
module visual_tracking_drive_controller
   import vtdc_pkg::*;
#(
   parameter int IMAGE_HALF_WIDTH = IMAGE_HALF_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_detected,
   input  logic [CX_W-1:0]              req_center_x,
   input  logic [DIST_W-1:0]            req_distance_mm,
   input  logic                         req_restart,
   input  logic                         req_cancel,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [FWD_W-1:0]             rsp_forward_speed,
   output logic signed [TURN_W-1:0]     rsp_turn_rate,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic [MODE_W-1:0]            rsp_mode,
   output logic                         rsp_done_res,
   input  logic                         csr_write_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   // offset from centre: cx - half width, magnitude up to max(half, 1023 - half)
   localparam int ERR_W   = $clog2(IMAGE_HALF_WIDTH + 1024) + 1;
   localparam int A_W     = $clog2(IMAGE_HALF_WIDTH + 1);
   localparam int P_W     = A_W + MAXT_W;
   localparam int SHIFT   = P_W + $clog2(IMAGE_HALF_WIDTH);
   localparam int RECIP_W = P_W + 1;
   localparam longint unsigned RECIP_L =
      ((64'd1 << SHIFT) + IMAGE_HALF_WIDTH - 1) / IMAGE_HALF_WIDTH;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_L[RECIP_W-1:0];
   localparam logic [ERR_W-1:0]   HALF_E = ERR_W'(IMAGE_HALF_WIDTH);
   localparam logic [A_W-1:0]     HALF_A = A_W'(IMAGE_HALF_WIDTH);

   // configuration registers
   logic signed [TURN_W-1:0] search_turn_ff;
   logic [MAXT_W-1:0]        max_turn_ff;
   logic [FWD_W-1:0]         max_fwd_ff;
   logic [FWD_W-1:0]         creep_ff;
   logic [CTOL_W-1:0]        centre_tol_ff;
   logic [DIST_W-1:0]        depth_tgt_ff;
   logic [DIST_W-1:0]        depth_tol_ff;
   logic [LOST_W-1:0]        lost_limit_ff;

   // input stage
   logic                s1_valid_ff;
   logic                s1_det_ff;
   logic [CX_W-1:0]     s1_cx_ff;
   logic [DIST_W-1:0]   s1_dist_ff;
   logic                s1_restart_ff;
   logic                s1_cancel_ff;
   logic [P_W-1:0]      s1_prod_ff;

   // controller state
   mode_type                 mode_ff, mode_in;
   logic                     seen_ff, seen_in;
   logic [LOST_W-1:0]        miss_ff, miss_in;
   logic [FWD_W-1:0]         held_fwd_ff, held_fwd_in;
   logic signed [TURN_W-1:0] held_turn_ff, held_turn_in;

   // response register
   logic                out_valid_ff;
   logic [FWD_W-1:0]    out_fwd_ff;
   logic [TURN_W-1:0]   out_turn_ff;
   status_type          out_status_ff, status_in;
   mode_type            out_mode_ff;
   logic                out_done_ff, done_in;

   logic advance;
   logic req_take;
   logic s1_move;

   assign advance   = ~out_valid_ff | ~rsp_stall;
   assign req_stall = s1_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;
   assign s1_move   = s1_valid_ff & advance;

   // first stage: |offset| clipped to half width, times max turn
   logic signed [ERR_W-1:0] in_err;
   logic [ERR_W-1:0]        in_abs;
   logic [A_W-1:0]          in_a;

   always_comb begin
      in_err = $signed(ERR_W'(req_center_x)) - $signed(HALF_E);
      in_abs = in_err[ERR_W-1] ? ERR_W'(-in_err) : ERR_W'(in_err);
      in_a   = (in_abs > HALF_E) ? HALF_A : in_abs[A_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_take) begin
         s1_det_ff     <= req_detected;
         s1_cx_ff      <= req_center_x;
         s1_dist_ff    <= req_distance_mm;
         s1_restart_ff <= req_restart;
         s1_cancel_ff  <= req_cancel;
         s1_prod_ff    <= P_W'(in_a) * P_W'(max_turn_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_turn_ff <= SEARCH_TURN_RST;
         max_turn_ff    <= MAX_TURN_RST;
         max_fwd_ff     <= MAX_FWD_RST;
         creep_ff       <= CREEP_RST;
         centre_tol_ff  <= CENTRE_TOL_RST;
         depth_tgt_ff   <= DEPTH_TGT_RST;
         depth_tol_ff   <= DEPTH_TOL_RST;
         lost_limit_ff  <= LOST_LIMIT_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SEARCH_TURN: search_turn_ff <= $signed(csr_wdata[TURN_W-1:0]);
            CSR_MAX_TURN:    max_turn_ff    <= csr_wdata[MAXT_W-1:0];
            CSR_MAX_FWD:     max_fwd_ff     <= csr_wdata[FWD_W-1:0];
            CSR_CREEP:       creep_ff       <= csr_wdata[FWD_W-1:0];
            CSR_CENTRE_TOL:  centre_tol_ff  <= csr_wdata[CTOL_W-1:0];
            CSR_DEPTH_TGT:   depth_tgt_ff   <= csr_wdata;
            CSR_DEPTH_TOL:   depth_tol_ff   <= csr_wdata;
            CSR_LOST_LIMIT:  lost_limit_ff  <= csr_wdata[LOST_W-1:0];
            default: ;
         endcase
      end
   end

   // second stage: divide by half width through the reciprocal, exact for P_W bits
   logic [P_W+RECIP_W-1:0]   scaled;
   logic [MAXT_W-1:0]        steer_mag;
   logic signed [TURN_W-1:0] steer;
   logic signed [ERR_W-1:0]  err;
   logic [ERR_W-1:0]         err_abs;
   logic [ERR_W-1:0]         tol_e;
   logic signed [DIST_W:0]   derr;
   logic [DIST_W-1:0]        derr_abs;
   logic [LOST_W:0]          miss_next;
   mode_type                 mode_eff;

   always_comb begin
      scaled    = (P_W+RECIP_W)'(s1_prod_ff) * (P_W+RECIP_W)'(RECIP);
      steer_mag = scaled[SHIFT +: MAXT_W];
      err       = $signed(ERR_W'(s1_cx_ff)) - $signed(HALF_E);
      err_abs   = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
      // steering sign is opposite to the offset
      steer     = err[ERR_W-1] ? $signed({1'b0, steer_mag})
                               : -$signed({1'b0, steer_mag});
      tol_e     = ERR_W'(centre_tol_ff);
      derr      = $signed({1'b0, s1_dist_ff}) - $signed({1'b0, depth_tgt_ff});
      derr_abs  = derr[DIST_W] ? (depth_tgt_ff - s1_dist_ff) : (s1_dist_ff - depth_tgt_ff);
      miss_next = {1'b0, miss_ff} + 1'b1;

      mode_in      = mode_ff;
      seen_in      = seen_ff;
      miss_in      = miss_ff;
      held_fwd_in  = held_fwd_ff;
      held_turn_in = held_turn_ff;
      status_in    = ST_SEARCHING;
      done_in      = 1'b0;
      mode_eff     = mode_ff;

      if (s1_cancel_ff) begin
         mode_in      = MODE_HALT;
         held_fwd_in  = '0;
         held_turn_in = '0;
      end else begin
         if (s1_restart_ff) begin
            mode_eff     = MODE_SEARCH;
            mode_in      = MODE_SEARCH;
            seen_in      = 1'b0;
            miss_in      = '0;
            held_fwd_in  = '0;
            held_turn_in = '0;
         end

         if (s1_det_ff) begin
            if (err_abs > tol_e) begin
               status_in = err[ERR_W-1] ? ST_LEFT : ST_RIGHT;
            end else begin
               status_in = ST_CENTRE;
            end
            seen_in = 1'b1;
            miss_in = '0;
         end else if (seen_in) begin
            if (miss_next > {1'b0, lost_limit_ff}) begin
               status_in = ST_LOST;
               miss_in   = '0;
            end else begin
               status_in = ST_LOST_BRIEF;
               miss_in   = miss_next[LOST_W-1:0];
            end
         end

         case (mode_eff)
            MODE_SEARCH: begin
               held_fwd_in  = creep_ff;
               held_turn_in = search_turn_ff;
               if (s1_det_ff) begin
                  mode_in = MODE_TRACK;
               end
            end
            MODE_TRACK: begin
               if (s1_det_ff) begin
                  held_fwd_in  = creep_ff;
                  held_turn_in = steer;
                  if (err_abs < tol_e) begin
                     mode_in = MODE_APPROACH;
                  end
               end
            end
            MODE_APPROACH: begin
               if (s1_det_ff) begin
                  if (err_abs > tol_e) begin
                     mode_in = MODE_TRACK;
                  end else begin
                     held_turn_in = '0;
                     if (derr[DIST_W]) begin
                        held_fwd_in = '0;
                     end else if (derr_abs > DIST_W'(max_fwd_ff)) begin
                        held_fwd_in = max_fwd_ff;
                     end else begin
                        held_fwd_in = derr_abs[FWD_W-1:0];
                     end
                     if (derr_abs < depth_tol_ff) begin
                        held_fwd_in = '0;
                        mode_in     = MODE_HALT;
                        done_in     = 1'b1;
                     end
                  end
               end
            end
            default: begin
               held_fwd_in  = '0;
               held_turn_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SEARCH;
         seen_ff      <= 1'b0;
         miss_ff      <= '0;
         held_fwd_ff  <= '0;
         held_turn_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_move) begin
            mode_ff      <= mode_in;
            seen_ff      <= seen_in;
            miss_ff      <= miss_in;
            held_fwd_ff  <= held_fwd_in;
            held_turn_ff <= held_turn_in;
         end
         if (advance) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
      if (s1_move) begin
         out_fwd_ff    <= held_fwd_in;
         out_turn_ff   <= held_turn_in;
         out_status_ff <= status_in;
         out_mode_ff   <= mode_in;
         out_done_ff   <= done_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_forward_speed = out_fwd_ff;
   assign rsp_turn_rate     = $signed(out_turn_ff);
   assign rsp_status        = out_status_ff;
   assign rsp_mode          = out_mode_ff;
   assign rsp_done_res      = out_done_ff;

endmodule

[bench/visual_tracking_drive_controller_check.sv]
`timescale 1ns / 100ps

module visual_tracking_drive_controller_check
   import vtdc_pkg::*;
#(
   parameter int IMAGE_HALF_WIDTH = IMAGE_HALF_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic                     req_detected,
   input  logic [CX_W-1:0]          req_center_x,
   input  logic [DIST_W-1:0]        req_distance_mm,
   input  logic                     req_restart,
   input  logic                     req_cancel,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [FWD_W-1:0]         rsp_forward_speed,
   input  logic signed [TURN_W-1:0] rsp_turn_rate,
   input  logic [STATUS_W-1:0]      rsp_status,
   input  logic [MODE_W-1:0]        rsp_mode,
   input  logic                     rsp_done_res,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   output int                       fail_count,
   output int                       awaited,
   output int                       arrivals
);

   typedef struct {
      logic [FWD_W-1:0]         forward;
      logic signed [TURN_W-1:0] turn;
      status_type               status;
      mode_type                 mode;
      logic                     done;
   } drive_command_type;

   drive_command_type commands_due[$];

   logic signed [TURN_W-1:0] search_turn;
   int max_turn, max_forward, creep, centre_tol, depth_goal, depth_tol, lost_cap;

   mode_type mode_now;
   logic     seen;
   int       misses, held_forward, held_turn;

   int fails = 0;
   int done_seen = 0;
   int pending_n = 0;

   assign fail_count = fails;
   assign awaited    = pending_n;
   assign arrivals   = done_seen;

   function automatic int magnitude(int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic void load_register(logic [CSR_IDX_W-1:0] idx,
                                         logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_SEARCH_TURN: search_turn = data[TURN_W-1:0];
         CSR_MAX_TURN:    max_turn    = data[MAXT_W-1:0];
         CSR_MAX_FWD:     max_forward = data[FWD_W-1:0];
         CSR_CREEP:       creep       = data[FWD_W-1:0];
         CSR_CENTRE_TOL:  centre_tol  = data[CTOL_W-1:0];
         CSR_DEPTH_TGT:   depth_goal  = data[DIST_W-1:0];
         CSR_DEPTH_TOL:   depth_tol   = data[DIST_W-1:0];
         CSR_LOST_LIMIT:  lost_cap    = data[LOST_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic drive_command_type predict_tick(logic det, logic [CX_W-1:0] cx,
                                                      logic [DIST_W-1:0] range_mm,
                                                      logic restart, logic cancel);
      drive_command_type c;
      int offset, lean, derr;
      offset = int'(cx) - IMAGE_HALF_WIDTH;
      c.status = ST_SEARCHING;
      c.done = 1'b0;
      if (cancel) begin
         mode_now = MODE_HALT;
         held_forward = 0;
         held_turn = 0;
      end else begin
         if (restart) begin
            mode_now = MODE_SEARCH;
            seen = 1'b0;
            misses = 0;
            held_forward = 0;
            held_turn = 0;
         end
         if (det) begin
            if (offset < -centre_tol) c.status = ST_LEFT;
            else if (offset > centre_tol) c.status = ST_RIGHT;
            else c.status = ST_CENTRE;
            seen = 1'b1;
            misses = 0;
         end else if (seen) begin
            // a limit lowered below the count still reports lost on the next miss
            if (misses + 1 > lost_cap) begin
               c.status = ST_LOST;
               misses = 0;
            end else begin
               c.status = ST_LOST_BRIEF;
               misses = misses + 1;
            end
         end
         case (mode_now)
            MODE_SEARCH: begin
               held_forward = creep;
               held_turn = search_turn;
               if (det) mode_now = MODE_TRACK;
            end
            MODE_TRACK: begin
               if (det) begin
                  // signed int division truncates toward zero
                  lean = (offset * max_turn) / IMAGE_HALF_WIDTH;
                  if (lean > max_turn) lean = max_turn;
                  else if (lean < -max_turn) lean = -max_turn;
                  held_forward = creep;
                  held_turn = -lean;
                  if (magnitude(offset) < centre_tol) mode_now = MODE_APPROACH;
               end
            end
            MODE_APPROACH: begin
               if (det) begin
                  if (magnitude(offset) > centre_tol) begin
                     mode_now = MODE_TRACK;
                  end else begin
                     derr = int'(range_mm) - depth_goal;
                     held_turn = 0;
                     if (derr < 0) held_forward = 0;
                     else if (derr > max_forward) held_forward = max_forward;
                     else held_forward = derr;
                     if (magnitude(derr) < depth_tol) begin
                        held_forward = 0;
                        held_turn = 0;
                        mode_now = MODE_HALT;
                        c.done = 1'b1;
                     end
                  end
               end
            end
            default: begin
               held_forward = 0;
               held_turn = 0;
            end
         endcase
      end
      c.forward = held_forward[FWD_W-1:0];
      c.turn = held_turn[TURN_W-1:0];
      c.mode = mode_now;
      return c;
   endfunction

   function automatic void report_mismatch(string field, logic signed [31:0] want,
                                           logic signed [31:0] got);
      fails++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
   endfunction

   function automatic void check_response();
      drive_command_type want;
      if (commands_due.size() == 0) begin
         fails++;
         $display("%0t: response transfer with no tick outstanding", $time);
      end else begin
         want = commands_due.pop_front();
         if (rsp_forward_speed !== want.forward)
            report_mismatch("forward_speed", want.forward, rsp_forward_speed);
         if (rsp_turn_rate !== want.turn)
            report_mismatch("turn_rate", want.turn, rsp_turn_rate);
         if (rsp_status !== want.status)
            report_mismatch("status", want.status, rsp_status);
         if (rsp_mode !== want.mode)
            report_mismatch("mode", want.mode, rsp_mode);
         if (rsp_done_res !== want.done)
            report_mismatch("done_res", want.done, rsp_done_res);
         if (want.done) done_seen++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         search_turn = SEARCH_TURN_RST;
         max_turn = MAX_TURN_RST;
         max_forward = MAX_FWD_RST;
         creep = CREEP_RST;
         centre_tol = CENTRE_TOL_RST;
         depth_goal = DEPTH_TGT_RST;
         depth_tol = DEPTH_TOL_RST;
         lost_cap = LOST_LIMIT_RST;
         mode_now = MODE_SEARCH;
         seen = 1'b0;
         misses = 0;
         held_forward = 0;
         held_turn = 0;
         commands_due.delete();
      end else begin
         if (csr_write_en) load_register(csr_index, csr_wdata);
         if (rsp_valid && !rsp_stall) check_response();
         if (req_valid && !req_stall)
            commands_due.push_back(predict_tick(req_detected, req_center_x,
                                                req_distance_mm, req_restart, req_cancel));
      end
      pending_n = commands_due.size();
   end

endmodule

[bench/visual_tracking_drive_controller_test.sv]
`timescale 1ns / 100ps

module visual_tracking_drive_controller_test
   import vtdc_pkg::*;
();

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 11;
   localparam int HOLD_LEN      = 80;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_detected = 1'b0;
   logic [CX_W-1:0]          req_center_x = '0;
   logic [DIST_W-1:0]        req_distance_mm = '0;
   logic                     req_restart = 1'b0;
   logic                     req_cancel = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [FWD_W-1:0]         rsp_forward_speed;
   logic signed [TURN_W-1:0] rsp_turn_rate;
   logic [STATUS_W-1:0]      rsp_status;
   logic [MODE_W-1:0]        rsp_mode;
   logic                     rsp_done_res;
   logic                     csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   int fail_count, awaited, arrivals;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int ticks_sent = 0;
   int tol_centre = CENTRE_TOL_RST;
   int tgt_depth = DEPTH_TGT_RST;
   int tol_depth = DEPTH_TOL_RST;

   always #HALF_PERIOD clock = ~clock;

   visual_tracking_drive_controller i_dut (.*);

   visual_tracking_drive_controller_check i_check (.*);

   // receiver pacing, with long hold-offs counted here
   always @(negedge clock) begin
      if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("visual_tracking_drive_controller_test: errors");
            $finish;
         end
      end
   end

   task automatic send_tick(logic det, int cx, int range_mm, logic rst, logic cnc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_detected <= det;
      req_center_x <= CX_W'(cx);
      req_distance_mm <= DIST_W'(range_mm);
      req_restart <= rst;
      req_cancel <= cnc;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      ticks_sent++;
      @(negedge clock);
   endtask

   task automatic random_tick();
      int cx, range_mm, span;
      logic det, rst, cnc;
      det = ($urandom_range(99) < 75);
      if ($urandom_range(99) < 50) begin
         span = tol_centre + 8;
         cx = IMAGE_HALF_WIDTH_DEF + int'($urandom_range(2 * span)) - span;
         cx = (cx < 0) ? 0 : (cx > 1023) ? 1023 : cx;
      end else if ($urandom_range(99) < 70) begin
         cx = $urandom_range(639);
      end else begin
         cx = $urandom_range(1023);
      end
      if ($urandom_range(99) < 50) begin
         // near the stopping distance so that approaches can end in a halt
         span = 2 * tol_depth + 20;
         range_mm = tgt_depth + int'($urandom_range(2 * span)) - span;
         range_mm = (range_mm < 0) ? 0 : (range_mm > 65535) ? 65535 : range_mm;
      end else begin
         range_mm = $urandom_range(65535);
      end
      rst = ($urandom_range(99) < 5);
      cnc = ($urandom_range(99) < 3);
      send_tick(det, cx, range_mm, rst, cnc);
   endtask

   // wait for every outstanding response, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (awaited != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(data);
      @(negedge clock);
   endtask

   task automatic end_writes();
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_config(int st, int mt, int mf, int cr, int ct, int dt, int dl,
                              int ll);
      write_reg(CSR_SEARCH_TURN, st);
      write_reg(CSR_MAX_TURN, mt);
      write_reg(CSR_MAX_FWD, mf);
      write_reg(CSR_CREEP, cr);
      write_reg(CSR_CENTRE_TOL, ct);
      write_reg(CSR_DEPTH_TGT, dt);
      write_reg(CSR_DEPTH_TOL, dl);
      write_reg(CSR_LOST_LIMIT, ll);
      end_writes();
      tol_centre = ct;
      tgt_depth = dt;
      tol_depth = dl;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed walk through the modes with reset register values
      send_tick(1'b0, 0, 0, 1'b1, 1'b0);
      send_tick(1'b0, 1023, 65535, 1'b0, 1'b0);
      send_tick(1'b1, 0, 0, 1'b0, 1'b0);
      send_tick(1'b1, 0, 0, 1'b0, 1'b0);
      send_tick(1'b1, 1023, 0, 1'b0, 1'b0);
      send_tick(1'b0, 500, 0, 1'b0, 1'b0);
      send_tick(1'b1, 320, 65535, 1'b0, 1'b0);
      send_tick(1'b1, 320, 65535, 1'b0, 1'b0);
      send_tick(1'b1, 320, 100, 1'b0, 1'b0);
      send_tick(1'b1, 400, 300, 1'b0, 1'b0);
      send_tick(1'b1, 290, 300, 1'b0, 1'b0);
      send_tick(1'b1, 335, 300, 1'b0, 1'b0);
      send_tick(1'b1, 350, 300, 1'b0, 1'b0);
      repeat (6) send_tick(1'b0, 320, 0, 1'b0, 1'b0);
      send_tick(1'b1, 320, 160, 1'b0, 1'b0);
      send_tick(1'b1, 320, 200, 1'b0, 1'b0);
      send_tick(1'b0, 0, 0, 1'b1, 1'b1);
      send_tick(1'b0, 0, 0, 1'b0, 1'b1);
      send_tick(1'b1, 320, 200, 1'b1, 1'b0);
      repeat (3) send_tick(1'b0, 0, 0, 1'b0, 1'b0);
      // lost limit dropped beneath the current miss count
      drain();
      write_reg(CSR_LOST_LIMIT, 1);
      end_writes();
      send_tick(1'b0, 0, 0, 1'b0, 1'b0);
      drain();
      write_reg(CSR_LOST_LIMIT, LOST_LIMIT_RST);
      end_writes();

      // reset values, back-to-back transfers
      repeat (100) random_tick();

      drain();
      load_config(-4000, 4000, 2000, 2000, 0, 0, 0, 0);
      send_idle_pct = 85;
      repeat (90) random_tick();

      drain();
      load_config(4000, 0, 0, 0, 320, 65535, 65535, 255);
      send_idle_pct = 0;
      stall_pct = 85;
      repeat (90) random_tick();

      drain();
      load_config(int'($urandom_range(8000)) - 4000, $urandom_range(4000),
                  $urandom_range(2000), $urandom_range(2000), $urandom_range(5, 80),
                  $urandom_range(65535), $urandom_range(10, 500), $urandom_range(8));
      send_idle_pct = 22;
      stall_pct = 22;
      repeat (110) random_tick();

      // long receiver hold-off while ticks keep coming, then a full pause
      drain();
      load_config(SEARCH_TURN_RST, MAX_TURN_RST, MAX_FWD_RST, CREEP_RST, CENTRE_TOL_RST,
                  DEPTH_TGT_RST, DEPTH_TOL_RST, LOST_LIMIT_RST);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_requests++;
      repeat (60) random_tick();
      drain();
      send_idle_pct = 22;
      stall_pct = 22;
      repeat (50) random_tick();

      drain();
      $display("summary: %0d ticks over five register settings, extremes included,",
               ticks_sent);
      $display("summary: with varied pacing and a long response hold-off; %0d arrivals",
               arrivals);
      if (fail_count == 0) begin
         $display("visual_tracking_drive_controller_test: clean");
      end else begin
         $display("visual_tracking_drive_controller_test: errors");
      end
      $finish;
   end

endmodule

[visual_tracking_drive_controller.f]
rtl/vtdc_pkg.sv
rtl/visual_tracking_drive_controller.sv
bench/visual_tracking_drive_controller_check.sv
bench/visual_tracking_drive_controller_test.sv
